// ===== rtl/beeq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the button and encoder event qualifier.
// Holds operation and action codes, register indexes and reset values.
// It depends on nothing else.
package beeq_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ENC_W    = 16;
  localparam int unsigned DET_W    = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_BUTTONS = 3;

  // Four encoder counts make one detent.
  localparam int unsigned DETENT_SHIFT = 2;

  localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
  localparam logic [OP_W-1:0] OP_SETVOL = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_MODE      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PLAYPAUSE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_NEXT      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PREV      = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_VOLUME    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLUME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME = 2'd3;

  localparam logic [7:0]       DEBOUNCE_RST   = 8'd5;
  localparam logic [15:0]      LONG_PRESS_RST = 16'd1500;
  localparam logic [VOL_W-1:0] MIN_VOL_RST    = 8'd0;
  localparam logic [VOL_W-1:0] MAX_VOL_RST    = 8'd30;
  localparam logic [VOL_W-1:0] VOL_RST        = 8'd15;

  // Debouncer outcome for one button on one poll.
  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_FALL,
    EDGE_RISE
  } edge_kind_t;

endpackage

// ===== rtl/button_encoder_event_qualifier.sv =====
`timescale 1ns / 1ps
// Top level of the button and encoder event qualifier.
// Debounce, long-press, encoder volume logic and the result register; uses beeq_pkg.
//
//   Channel  Ports                                        Direction
//   in       in_valid/in_ready, op, time, pins, enc, vol  sink
//   out      out_valid/out_ready, action, volume          source
//   cfg      cfg_we, cfg_index, cfg_wdata                 sink, write only
//
// One item is taken per cycle; its result appears in the result register at
// the next edge. The state update and the result are one combinational pass.
// An item is taken whenever the result register is empty or being drained.
// Reset is synchronous and restores the documented register and state values.
module button_encoder_event_qualifier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [beeq_pkg::OP_W-1:0]            in_op,
  input  logic [beeq_pkg::TIME_W-1:0]          in_now_ms,
  input  logic                                 in_play_raw,
  input  logic                                 in_next_raw,
  input  logic                                 in_prev_raw,
  input  logic signed [beeq_pkg::ENC_W-1:0]    in_encoder_position,
  input  logic [beeq_pkg::VOL_W-1:0]           in_volume_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [beeq_pkg::ACTION_W-1:0]        out_action,
  output logic [beeq_pkg::VOL_W-1:0]           out_volume,
  input  logic                                 cfg_we,
  input  logic [beeq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [beeq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import beeq_pkg::*;

  logic [7:0]       debounce_ms_r;
  logic [15:0]      long_press_ms_r;
  logic [VOL_W-1:0] min_volume_r;
  logic [VOL_W-1:0] max_volume_r;

  logic [NUM_BUTTONS-1:0]  stable_r, stable_nxt;
  logic [NUM_BUTTONS-1:0]  last_raw_r, last_raw_nxt;
  logic [TIME_W-1:0]       change_time_r [NUM_BUTTONS];
  logic [TIME_W-1:0]       change_time_nxt [NUM_BUTTONS];
  logic [TIME_W-1:0]       press_start_r, press_start_nxt;
  logic                    long_seen_r, long_seen_nxt;
  logic signed [DET_W-1:0] baseline_r, baseline_nxt;
  logic [VOL_W-1:0]        volume_r, volume_nxt;

  logic                out_valid_r;
  logic [ACTION_W-1:0] out_action_r, action_nxt;
  logic [VOL_W-1:0]    out_volume_r;

  logic                     accept;
  logic [NUM_BUTTONS-1:0]   raw;
  edge_kind_t               edge_ev [NUM_BUTTONS];
  logic signed [ENC_W:0]    enc_adj;
  logic signed [ENC_W:0]    enc_shift;
  logic signed [DET_W-1:0]  detents;
  logic signed [DET_W:0]    det_diff;
  logic signed [VOL_W+8:0]  vol_sum;
  logic [TIME_W-1:0]        elapsed [NUM_BUTTONS];
  logic [TIME_W-1:0]        held;

  function automatic logic [VOL_W-1:0] clamp_vol(input logic signed [VOL_W+8:0] x,
                                                 input logic [VOL_W-1:0] lo,
                                                 input logic [VOL_W-1:0] hi);
    logic [VOL_W-1:0] res;
    if (x < $signed({9'b0, lo})) begin
      res = lo;
    end else if (x > $signed({9'b0, hi})) begin
      res = hi;
    end else begin
      res = x[VOL_W-1:0];
    end
    return res;
  endfunction

  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_volume = out_volume_r;

  assign raw = {in_prev_raw, in_next_raw, in_play_raw};

  // Division by four truncated toward zero.
  assign enc_adj   = {in_encoder_position[ENC_W-1], in_encoder_position}
                     + (in_encoder_position[ENC_W-1] ? 17'sd3 : 17'sd0);
  assign enc_shift = enc_adj >>> DETENT_SHIFT;
  assign detents   = enc_shift[DET_W-1:0];
  assign det_diff  = {detents[DET_W-1], detents} - {baseline_r[DET_W-1], baseline_r};
  assign vol_sum   = $signed({9'b0, volume_r})
                     + {{(VOL_W+9-(DET_W+1)){det_diff[DET_W]}}, det_diff};

  always_comb begin
    stable_nxt      = stable_r;
    last_raw_nxt    = last_raw_r;
    change_time_nxt = change_time_r;
    press_start_nxt = press_start_r;
    long_seen_nxt   = long_seen_r;
    baseline_nxt    = baseline_r;
    volume_nxt      = volume_r;
    action_nxt      = ACT_NONE;
    held            = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      edge_ev[i] = EDGE_NONE;
      elapsed[i] = in_now_ms - change_time_r[i];
    end
    case (in_op)
      OP_POLL: begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (raw[i] != last_raw_r[i]) begin
            last_raw_nxt[i]    = raw[i];
            change_time_nxt[i] = in_now_ms;
          end else if (elapsed[i] >= {24'b0, debounce_ms_r} && raw[i] != stable_r[i]) begin
            stable_nxt[i] = raw[i];
            edge_ev[i]    = raw[i] ? EDGE_RISE : EDGE_FALL;
          end
        end
        if (edge_ev[0] == EDGE_FALL) begin
          press_start_nxt = in_now_ms;
          long_seen_nxt   = 1'b0;
        end
        held = in_now_ms - press_start_nxt;
        if (!stable_nxt[0] && !long_seen_nxt && held > {16'b0, long_press_ms_r}) begin
          long_seen_nxt = 1'b1;
          action_nxt    = ACT_MODE;
        end else if (edge_ev[0] == EDGE_RISE && !long_seen_nxt) begin
          action_nxt = ACT_PLAYPAUSE;
        end else if (edge_ev[1] == EDGE_FALL) begin
          action_nxt = ACT_NEXT;
        end else if (edge_ev[2] == EDGE_FALL) begin
          action_nxt = ACT_PREV;
        end else if (detents != baseline_r) begin
          volume_nxt   = clamp_vol(vol_sum, min_volume_r, max_volume_r);
          baseline_nxt = detents;
          action_nxt   = ACT_VOLUME;
        end
      end
      OP_SETVOL: begin
        volume_nxt = clamp_vol($signed({9'b0, in_volume_value}), min_volume_r, max_volume_r);
      end
      OP_START: begin
        stable_nxt   = raw;
        last_raw_nxt = raw;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          change_time_nxt[i] = in_now_ms;
        end
        baseline_nxt = detents;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r   <= DEBOUNCE_RST;
      long_press_ms_r <= LONG_PRESS_RST;
      min_volume_r    <= MIN_VOL_RST;
      max_volume_r    <= MAX_VOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ms_r   <= cfg_wdata[7:0];
        REG_LONG_PRESS: long_press_ms_r <= cfg_wdata;
        REG_MIN_VOLUME: min_volume_r    <= cfg_wdata[VOL_W-1:0];
        REG_MAX_VOLUME: max_volume_r    <= cfg_wdata[VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= '1;
      last_raw_r    <= '1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_time_r[i] <= '0;
      end
      press_start_r <= '0;
      long_seen_r   <= 1'b0;
      baseline_r    <= '0;
      volume_r      <= VOL_RST;
    end else if (accept) begin
      stable_r      <= stable_nxt;
      last_raw_r    <= last_raw_nxt;
      change_time_r <= change_time_nxt;
      press_start_r <= press_start_nxt;
      long_seen_r   <= long_seen_nxt;
      baseline_r    <= baseline_nxt;
      volume_r      <= volume_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_action_r <= action_nxt;
      out_volume_r <= volume_nxt;
    end
  end

endmodule

// ===== rtl/beeq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the button and encoder event qualifier.
// Uses beeq_pkg; bound to button_encoder_event_qualifier at the end of this file.
module beeq_port_props (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [beeq_pkg::OP_W-1:0]           in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [beeq_pkg::ACTION_W-1:0]       out_action,
  input logic [beeq_pkg::VOL_W-1:0]          out_volume
);
  import beeq_pkg::*;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_non_poll_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op != OP_POLL |=> out_action == ACT_NONE)
    else $error("non-poll item produced an action");

  a_empty_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_volume))
    else $error("stalled result changed");

endmodule

bind button_encoder_event_qualifier beeq_port_props u_beeq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_op      (in_op),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_action (out_action),
  .out_volume (out_volume)
);

// ===== tb/beeq_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the button and encoder event qualifier: watches the input,
// result and register write ports, predicts each result and compares it.
// Depends on beeq_pkg for the operation, action and register codes.
module beeq_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [beeq_pkg::OP_W-1:0]         in_op,
  input  logic [beeq_pkg::TIME_W-1:0]       in_now_ms,
  input  logic                              in_play_raw,
  input  logic                              in_next_raw,
  input  logic                              in_prev_raw,
  input  logic signed [beeq_pkg::ENC_W-1:0] in_encoder_position,
  input  logic [beeq_pkg::VOL_W-1:0]        in_volume_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [beeq_pkg::ACTION_W-1:0]     out_action,
  input  logic [beeq_pkg::VOL_W-1:0]        out_volume,
  input  logic                              cfg_we,
  input  logic [beeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [beeq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int unsigned                       fail_count,
  output int unsigned                       outstanding
);
  import beeq_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VOL_W-1:0]    volume;
  } qual_result_t;

  logic [7:0]        deb_ms;
  logic [15:0]       long_ms;
  logic [VOL_W-1:0]  min_vol;
  logic [VOL_W-1:0]  max_vol;

  logic              stable_lvl [NUM_BUTTONS];
  logic              last_raw [NUM_BUTTONS];
  logic [TIME_W-1:0] change_t [NUM_BUTTONS];
  logic [TIME_W-1:0] press_t;
  logic              long_seen;
  int                det_base;
  logic [VOL_W-1:0]  cur_vol;

  qual_result_t      pending_events [$];
  qual_result_t      want;
  int unsigned       errs;

  function automatic void reset_state();
    deb_ms    = DEBOUNCE_RST;
    long_ms   = LONG_PRESS_RST;
    min_vol   = MIN_VOL_RST;
    max_vol   = MAX_VOL_RST;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      stable_lvl[b] = 1'b1;
      last_raw[b]   = 1'b1;
      change_t[b]   = '0;
    end
    press_t   = '0;
    long_seen = 1'b0;
    det_base  = 0;
    cur_vol   = VOL_RST;
  endfunction

  function automatic int detent_of(logic signed [ENC_W-1:0] pos);
    int v;
    v = pos;
    return v / (1 << DETENT_SHIFT);
  endfunction

  function automatic logic [VOL_W-1:0] clamp_vol(int x);
    if (x < int'(min_vol)) return min_vol;
    if (x > int'(max_vol)) return max_vol;
    return x[VOL_W-1:0];
  endfunction

  function automatic edge_kind_t debounce_button(int b, logic raw, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    if (raw != last_raw[b]) begin
      last_raw[b] = raw;
      change_t[b] = now;
      return EDGE_NONE;
    end
    elapsed = now - change_t[b];
    if (elapsed >= {24'd0, deb_ms} && raw != stable_lvl[b]) begin
      stable_lvl[b] = raw;
      return raw ? EDGE_RISE : EDGE_FALL;
    end
    return EDGE_NONE;
  endfunction

  function automatic qual_result_t qualify_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                                                logic [NUM_BUTTONS-1:0] raw,
                                                logic signed [ENC_W-1:0] enc,
                                                logic [VOL_W-1:0] vreq);
    edge_kind_t        e_play, e_next, e_prev;
    logic [TIME_W-1:0] held;
    logic [ACTION_W-1:0] act;
    int                d;
    qual_result_t      r;
    act = ACT_NONE;
    case (op)
      OP_POLL: begin
        e_play = debounce_button(0, raw[0], now);
        e_next = debounce_button(1, raw[1], now);
        e_prev = debounce_button(2, raw[2], now);
        if (e_play == EDGE_FALL) begin
          press_t   = now;
          long_seen = 1'b0;
        end
        held = now - press_t;
        if (stable_lvl[0] == 1'b0 && !long_seen && held > {16'd0, long_ms}) begin
          long_seen = 1'b1;
          act = ACT_MODE;
        end else if (e_play == EDGE_RISE && !long_seen) begin
          act = ACT_PLAYPAUSE;
        end else if (e_next == EDGE_FALL) begin
          act = ACT_NEXT;
        end else if (e_prev == EDGE_FALL) begin
          act = ACT_PREV;
        end else begin
          d = detent_of(enc);
          if (d != det_base) begin
            cur_vol  = clamp_vol(int'(cur_vol) + (d - det_base));
            det_base = d;
            act = ACT_VOLUME;
          end
        end
      end
      OP_SETVOL: begin
        cur_vol = clamp_vol(int'(vreq));
      end
      OP_START: begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          stable_lvl[b] = raw[b];
          last_raw[b]   = raw[b];
          change_t[b]   = now;
        end
        det_base = detent_of(enc);
      end
      default: ;
    endcase
    r.action = act;
    r.volume = cur_vol;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_state();
      pending_events.delete();
      errs = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:   deb_ms  = cfg_wdata[7:0];
          REG_LONG_PRESS: long_ms = cfg_wdata[15:0];
          REG_MIN_VOLUME: min_vol = cfg_wdata[VOL_W-1:0];
          REG_MAX_VOLUME: max_vol = cfg_wdata[VOL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: result with no item waiting: action %0d volume %0d",
                   $time, out_action, out_volume);
          errs++;
        end else begin
          want = pending_events.pop_front();
          if (out_action !== want.action) begin
            $display("%0t: action mismatch: expected %0d actual %0d",
                     $time, want.action, out_action);
            errs++;
          end
          if (out_volume !== want.volume) begin
            $display("%0t: volume mismatch: expected %0d actual %0d",
                     $time, want.volume, out_volume);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_events.push_back(qualify_item(in_op, in_now_ms,
                                              {in_prev_raw, in_next_raw, in_play_raw},
                                              in_encoder_position, in_volume_value));
      end
      fail_count <= errs;
      outstanding <= pending_events.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the event qualifier testbench: clock, reset, register settings, directed
// and random items, and random receiver stalls. Uses beeq_pkg and beeq_checker.
module testbench;
  import beeq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op;
  logic [TIME_W-1:0]       in_now_ms;
  logic                    in_play_raw;
  logic                    in_next_raw;
  logic                    in_prev_raw;
  logic signed [ENC_W-1:0] in_encoder_position;
  logic [VOL_W-1:0]        in_volume_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [ACTION_W-1:0]     out_action;
  logic [VOL_W-1:0]        out_volume;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  int unsigned             fail_count;
  int unsigned             outstanding;
  int unsigned             cycle_count = 0;

  logic [TIME_W-1:0]       clock_ms;
  logic                    play_lvl, next_lvl, prev_lvl;
  logic signed [ENC_W-1:0] enc_pos;
  int                      step_max;
  bit                      quiet;
  bit                      hold_now;
  bit                      hold_taken;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  button_encoder_event_qualifier uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_now_ms(in_now_ms),
    .in_play_raw(in_play_raw), .in_next_raw(in_next_raw), .in_prev_raw(in_prev_raw),
    .in_encoder_position(in_encoder_position), .in_volume_value(in_volume_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_action(out_action),
    .out_volume(out_volume),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  beeq_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_now_ms(in_now_ms),
    .in_play_raw(in_play_raw), .in_next_raw(in_next_raw), .in_prev_raw(in_prev_raw),
    .in_encoder_position(in_encoder_position), .in_volume_value(in_volume_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_action(out_action),
    .out_volume(out_volume),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic pl, input logic nx, input logic pv,
                           input logic signed [ENC_W-1:0] enc, input logic [VOL_W-1:0] vol);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_op               <= op;
    in_now_ms           <= now;
    in_play_raw         <= pl;
    in_next_raw         <= nx;
    in_prev_raw         <= pv;
    in_encoder_position <= enc;
    in_volume_value     <= vol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] deb, input logic [15:0] lp,
                            input logic [7:0] minv, input logic [7:0] maxv);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= {junk, deb};
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    junk = 8'($urandom);
    cfg_index <= REG_MIN_VOLUME;
    cfg_wdata <= {junk, minv};
    @(posedge clk);
    junk = 8'($urandom);
    cfg_index <= REG_MAX_VOLUME;
    cfg_wdata <= {junk, maxv};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly realistic button activity with slowly moving time and encoder, plus
  // glitches, time jumps, other operations and a little fully random noise.
  task automatic random_items(input int n);
    int r, re;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
    logic              pl, nx, pv;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 3) clock_ms = clock_ms + $urandom_range(0, 70000);
      else if ($urandom_range(0, 199) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      if (play_lvl) begin
        if ($urandom_range(0, 99) < 6) play_lvl = 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        play_lvl = 1'b1;
      end
      if ($urandom_range(0, 99) < 7) next_lvl = ~next_lvl;
      if ($urandom_range(0, 99) < 7) prev_lvl = ~prev_lvl;
      pl = play_lvl ^ ($urandom_range(0, 99) < 3);
      nx = next_lvl ^ ($urandom_range(0, 99) < 3);
      pv = prev_lvl ^ ($urandom_range(0, 99) < 3);
      re = $urandom_range(0, 99);
      if (re < 2) enc_pos = 16'($urandom);
      else if (re == 2) enc_pos = 16'sh8000;
      else if (re == 3) enc_pos = 16'sh7FFF;
      else enc_pos = 16'(enc_pos + int'($urandom_range(0, 16)) - 8);
      now = clock_ms;
      op  = OP_POLL;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        op = OP_SETVOL;
      end else if (r < 11) begin
        op = OP_START;
      end else if (r < 13) begin
        op = OP_UNUSED;
      end else if (r < 15) begin
        now = $urandom;
        pl  = 1'($urandom);
        nx  = 1'($urandom);
        pv  = 1'($urandom);
      end
      send_item(op, now, pl, nx, pv, enc_pos, 8'($urandom));
    end
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        for (int k = 0; k < 300; k++) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("button_encoder_event_qualifier test failed");
    $finish;
  end

  initial begin : stimulus
    in_valid            = 1'b0;
    in_op               = OP_POLL;
    in_now_ms           = '0;
    in_play_raw         = 1'b1;
    in_next_raw         = 1'b1;
    in_prev_raw         = 1'b1;
    in_encoder_position = '0;
    in_volume_value     = '0;
    cfg_we              = 1'b0;
    cfg_index           = REG_DEBOUNCE;
    cfg_wdata           = '0;
    quiet    = 1'b0;
    hold_now = 1'b0;
    clock_ms = 32'd2000;
    play_lvl = 1'b1;
    next_lvl = 1'b1;
    prev_lvl = 1'b1;
    enc_pos  = '0;
    step_max = 40;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings.
    send_item(OP_START, 32'd100, 1'b1, 1'b1, 1'b1, 16'sd0, 8'd0);
    send_item(OP_POLL, 32'd101, 1'b0, 1'b1, 1'b1, 16'sd0, 8'd0);
    send_item(OP_POLL, 32'd110, 1'b0, 1'b1, 1'b1, 16'sd0, 8'd0);
    send_item(OP_POLL, 32'd130, 1'b1, 1'b1, 1'b1, 16'sd0, 8'd0);
    send_item(OP_POLL, 32'd140, 1'b1, 1'b1, 1'b1, 16'sd0, 8'd0);
    send_item(OP_POLL, 32'd150, 1'b1, 1'b0, 1'b1, 16'sd8, 8'd0);
    send_item(OP_POLL, 32'd160, 1'b1, 1'b0, 1'b1, 16'sd8, 8'd0);
    send_item(OP_POLL, 32'd161, 1'b1, 1'b0, 1'b1, 16'sd8, 8'd0);
    send_item(OP_POLL, 32'd170, 1'b1, 1'b1, 1'b0, 16'sd8, 8'd0);
    send_item(OP_POLL, 32'd180, 1'b1, 1'b1, 1'b0, -16'sd5, 8'd0);
    send_item(OP_POLL, 32'd181, 1'b1, 1'b1, 1'b1, -16'sd5, 8'd0);
    send_item(OP_POLL, 32'd190, 1'b1, 1'b1, 1'b1, 16'sh8000, 8'd0);
    send_item(OP_POLL, 32'd191, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_SETVOL, 32'd192, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 8'd255);
    send_item(OP_SETVOL, 32'd193, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_POLL, 32'd200, 1'b0, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_POLL, 32'd210, 1'b0, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_POLL, 32'd1711, 1'b0, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_POLL, 32'd1720, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_POLL, 32'd1730, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 8'd0);
    send_item(OP_START, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, -16'sd3, 8'd0);
    send_item(OP_POLL, 32'hFFFF_FFF8, 1'b1, 1'b0, 1'b1, -16'sd3, 8'd0);
    send_item(OP_POLL, 32'h0000_0002, 1'b1, 1'b0, 1'b1, -16'sd3, 8'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sh8000, 8'hFF);
    send_item(OP_POLL, 32'd3, 1'b1, 1'b1, 1'b1, 16'sd4, 8'd0);
    random_items(230);

    drain();
    set_config(8'd0, 16'd1, 8'd0, 8'd255);
    step_max = 3;
    random_items(120);
    hold_now = 1'b1;
    random_items(130);

    drain();
    set_config(8'd255, 16'd65535, 8'd255, 8'd0);
    step_max = 600;
    random_items(250);

    drain();
    set_config(8'd3, 16'd40, 8'd10, 8'd20);
    step_max = 4;
    quiet = 1'b1;
    random_items(150);
    quiet = 1'b0;
    random_items(100);

    drain();
    set_config(8'd8, 16'd300, 8'd40, 8'd12);
    step_max = 20;
    random_items(250);

    drain();
    set_config(8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    step_max = $urandom_range(2, 300);
    random_items(250);

    drain();
    if (fail_count == 0) begin
      $display("button_encoder_event_qualifier test passed");
    end else begin
      $display("button_encoder_event_qualifier test failed");
    end
    $finish;
  end

endmodule
